### src/multichannel_byte_histogram_top_defines.svh
// Assertion macros used by the histogram checker.
`ifndef MULTICHANNEL_BYTE_HISTOGRAM_TOP_DEFINES_SVH
`define MULTICHANNEL_BYTE_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication checked at every rising clock edge.
`define MBH_ASSERT_IMP(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("histogram assertion failed");

// Next-cycle implication checked at every rising clock edge.
`define MBH_ASSERT_NXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("histogram assertion failed");

`endif

### src/mbh_pkg.sv
// Shared types, constants and helpers for the multichannel byte histogram.
`timescale 1ns / 1ps

package mbh_pkg;

   localparam int BINS         = 256;
   localparam int MAX_CHANNELS = 4;
   localparam int COUNT_BITS   = 24;
   localparam int DEPTH        = MAX_CHANNELS * BINS;
   localparam int ADDR_BITS    = $clog2(DEPTH);
   localparam int CHAN_LIMIT   = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;

   localparam int CMD_BITS   = 2;
   localparam int PIXEL_BITS = 8;
   localparam int RCH_BITS   = 2;
   localparam int CSR_BITS   = 3;
   localparam int CSR_DATA_BITS = 24;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [CMD_BITS-1:0]   cmd_type;
   typedef logic [CSR_BITS-1:0]   csr_index_type;

   localparam count_type COUNT_MAX = '1;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_COUNT = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   localparam logic [1:0] LAYOUT_LINES  = 2'd1;
   localparam logic [1:0] LAYOUT_PIXELS = 2'd2;

   localparam csr_index_type REG_LAYOUT     = 3'd0;
   localparam csr_index_type REG_CHANNELS   = 3'd1;
   localparam csr_index_type REG_PLANE_SIZE = 3'd2;
   localparam csr_index_type REG_LINE_WIDTH = 3'd3;
   localparam csr_index_type REG_LINE_COUNT = 3'd4;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_state;
      logic mem_read;
      logic update;
      logic sweep;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    sweep_last;
   } ctrl_status_type;

   function automatic addr_type mem_addr(input logic [2:0] ch, input logic [7:0] bin);
      int full;
      full = int'(ch) * BINS + int'(bin);
      return full[ADDR_BITS-1:0];
   endfunction

endpackage

### src/mbh_if.sv
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps

interface mbh_req_if;
   logic                               valid;
   logic                               ready;
   logic [mbh_pkg::CMD_BITS-1:0]       cmd;
   logic [mbh_pkg::PIXEL_BITS-1:0]     pixel_value;
   logic [mbh_pkg::RCH_BITS-1:0]       read_channel;
   logic [mbh_pkg::PIXEL_BITS-1:0]     read_bin;

   modport source (output valid, cmd, pixel_value, read_channel, read_bin, input ready);
   modport sink (input valid, cmd, pixel_value, read_channel, read_bin, output ready);
endinterface

interface mbh_rsp_if;
   logic                   valid;
   logic                   ready;
   mbh_pkg::count_type     bin_count;
   mbh_pkg::count_type     max_count;
   logic                   ignored;

   modport source (output valid, bin_count, max_count, ignored, input ready);
   modport sink (input valid, bin_count, max_count, ignored, output ready);
endinterface

### src/mbh_ctrl.sv
// Controller state machine that sequences reads, updates and clearing sweeps.
`timescale 1ns / 1ps

module mbh_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mbh_pkg::ctrl_cmd_type    ctrl,
   input  mbh_pkg::ctrl_status_type status
);

   mbh_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbh_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = (state_ff == mbh_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      case (state_ff)
         mbh_pkg::ST_INIT: begin
            ctrl.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = mbh_pkg::ST_IDLE;
            end
         end
         mbh_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               ctrl.capture = 1'b1;
               state_in     = mbh_pkg::ST_READ;
            end
         end
         mbh_pkg::ST_READ: begin
            if (status.cmd == mbh_pkg::CMD_CLEAR) begin
               ctrl.clear_state = 1'b1;
               state_in         = mbh_pkg::ST_CLEAR;
            end else begin
               ctrl.mem_read = 1'b1;
               state_in      = mbh_pkg::ST_UPDATE;
            end
         end
         mbh_pkg::ST_UPDATE: begin
            ctrl.update   = 1'b1;
            ctrl.load_rsp = 1'b1;
            state_in      = mbh_pkg::ST_IDLE;
         end
         mbh_pkg::ST_CLEAR: begin
            ctrl.sweep = 1'b1;
            if (status.sweep_last) begin
               ctrl.load_rsp = 1'b1;
               state_in      = mbh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbh_pkg::ST_INIT;
         end
      endcase

      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/mbh_datapath.sv
// Datapath with bin memory, layout tracking, maximum tracking and response registers.
`timescale 1ns / 1ps

module mbh_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  mbh_pkg::csr_index_type               csr_index,
   input  logic [mbh_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic [mbh_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic [mbh_pkg::PIXEL_BITS-1:0]       req_pixel_value,
   input  logic [mbh_pkg::RCH_BITS-1:0]         req_read_channel,
   input  logic [mbh_pkg::PIXEL_BITS-1:0]       req_read_bin,
   input  mbh_pkg::ctrl_cmd_type                ctrl,
   output mbh_pkg::ctrl_status_type             status,
   output mbh_pkg::count_type                   rsp_bin_count,
   output mbh_pkg::count_type                   rsp_max_count,
   output logic                                 rsp_ignored
);

   logic [1:0]  layout_ff;
   logic [2:0]  chan_count_ff;
   logic [23:0] plane_size_ff;
   logic [15:0] line_width_ff;
   logic [15:0] line_count_ff;

   mbh_pkg::cmd_type                   lcmd_ff;
   logic [mbh_pkg::PIXEL_BITS-1:0]     lpix_ff;
   logic [mbh_pkg::RCH_BITS-1:0]       lrch_ff;
   logic [mbh_pkg::PIXEL_BITS-1:0]     lrbin_ff;

   mbh_pkg::count_type mem [mbh_pkg::DEPTH];
   mbh_pkg::count_type rdata_ff;
   mbh_pkg::addr_type  sweep_ff, sweep_in;
   mbh_pkg::addr_type  raddr, waddr, count_addr;
   mbh_pkg::count_type wdata;
   logic               we;

   mbh_pkg::count_type largest_ff, largest_in;
   logic [23:0]        run_ff, run_in, run_inc;
   logic [2:0]         chan_ff, chan_in, chan_inc;
   logic [15:0]        line_ff, line_in, line_inc;
   logic               done_ff, done_in;

   logic [2:0]         nch;
   logic               ign, bump, count_en, is_count;
   mbh_pkg::count_type new_count;

   mbh_pkg::count_type rsp_bin_ff;
   mbh_pkg::count_type rsp_max_ff;
   logic               rsp_ign_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff     <= 2'd0;
         chan_count_ff <= 3'd1;
         plane_size_ff <= 24'd1;
         line_width_ff <= 16'd1;
         line_count_ff <= 16'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            mbh_pkg::REG_LAYOUT:     layout_ff     <= csr_write_data[1:0];
            mbh_pkg::REG_CHANNELS:   chan_count_ff <= csr_write_data[2:0];
            mbh_pkg::REG_PLANE_SIZE: plane_size_ff <= csr_write_data[23:0];
            mbh_pkg::REG_LINE_WIDTH: line_width_ff <= csr_write_data[15:0];
            mbh_pkg::REG_LINE_COUNT: line_count_ff <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         lcmd_ff  <= req_cmd;
         lpix_ff  <= req_pixel_value;
         lrch_ff  <= req_read_channel;
         lrbin_ff <= req_read_bin;
      end
   end

   assign count_addr = mbh_pkg::mem_addr(chan_ff, lpix_ff);
   assign raddr = (lcmd_ff == mbh_pkg::CMD_READ) ?
                  mbh_pkg::mem_addr({1'b0, lrch_ff}, lrbin_ff) : count_addr;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (ctrl.mem_read) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      nch = (chan_count_ff == 3'd0) ? 3'd1 : chan_count_ff;
      if (nch > 3'(mbh_pkg::CHAN_LIMIT)) begin
         nch = 3'(mbh_pkg::CHAN_LIMIT);
      end
      run_inc  = run_ff + 24'd1;
      chan_inc = chan_ff + 3'd1;
      line_inc = line_ff + 16'd1;
      ign      = 1'b0;
      bump     = 1'b0;
      run_in   = run_ff;
      chan_in  = chan_ff;
      line_in  = line_ff;
      done_in  = done_ff;
      if (done_ff) begin
         ign = 1'b1;
      end else begin
         case (layout_ff)
            mbh_pkg::LAYOUT_LINES: begin
               if (line_width_ff == 16'd0 || line_count_ff == 16'd0 || chan_ff >= nch ||
                   line_ff >= line_count_ff) begin
                  ign     = 1'b1;
                  done_in = 1'b1;
               end else begin
                  bump   = 1'b1;
                  run_in = run_inc;
                  if (run_inc >= {8'd0, line_width_ff}) begin
                     run_in  = 24'd0;
                     chan_in = chan_inc;
                     if (chan_inc >= nch) begin
                        chan_in = 3'd0;
                        line_in = line_inc;
                        if (line_inc >= line_count_ff) begin
                           done_in = 1'b1;
                        end
                     end
                  end
               end
            end
            mbh_pkg::LAYOUT_PIXELS: begin
               if (plane_size_ff == 24'd0 || chan_ff >= 3'd3 || run_ff >= plane_size_ff) begin
                  ign     = 1'b1;
                  done_in = 1'b1;
               end else begin
                  bump    = 1'b1;
                  chan_in = chan_inc;
                  if (chan_inc >= 3'd3) begin
                     chan_in = 3'd0;
                     run_in  = run_inc;
                     if (run_inc >= plane_size_ff) begin
                        done_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
               if (plane_size_ff == 24'd0 || chan_ff >= nch) begin
                  ign     = 1'b1;
                  done_in = 1'b1;
               end else begin
                  bump   = 1'b1;
                  run_in = run_inc;
                  if (run_inc >= plane_size_ff) begin
                     run_in  = 24'd0;
                     chan_in = chan_inc;
                     if (chan_inc >= nch) begin
                        done_in = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   assign is_count  = ctrl.update && (lcmd_ff == mbh_pkg::CMD_COUNT);
   assign count_en  = is_count && bump && ({1'b0, chan_ff} < 4'(mbh_pkg::MAX_CHANNELS));
   assign new_count = (rdata_ff == mbh_pkg::COUNT_MAX) ? rdata_ff :
                      rdata_ff + mbh_pkg::count_type'(1);

   always_comb begin
      we    = 1'b0;
      waddr = sweep_ff;
      wdata = '0;
      if (ctrl.sweep) begin
         we = 1'b1;
      end else if (count_en) begin
         we    = 1'b1;
         waddr = count_addr;
         wdata = new_count;
      end
   end

   always_comb begin
      if (ctrl.clear_state) begin
         largest_in = '0;
      end else if (count_en && (new_count > largest_ff)) begin
         largest_in = new_count;
      end else begin
         largest_in = largest_ff;
      end
      if (ctrl.sweep) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + mbh_pkg::addr_type'(1);
      end else begin
         sweep_in = sweep_ff;
      end
   end

   assign status.sweep_last = (sweep_ff == mbh_pkg::addr_type'(mbh_pkg::DEPTH - 1));
   assign status.cmd        = lcmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         largest_ff <= '0;
         sweep_ff   <= '0;
         run_ff     <= 24'd0;
         chan_ff    <= 3'd0;
         line_ff    <= 16'd0;
         done_ff    <= 1'b0;
      end else begin
         largest_ff <= largest_in;
         sweep_ff   <= sweep_in;
         if (ctrl.clear_state) begin
            run_ff  <= 24'd0;
            chan_ff <= 3'd0;
            line_ff <= 16'd0;
            done_ff <= 1'b0;
         end else if (is_count) begin
            run_ff  <= run_in;
            chan_ff <= chan_in;
            line_ff <= line_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         if (lcmd_ff == mbh_pkg::CMD_READ && int'(lrch_ff) < mbh_pkg::MAX_CHANNELS) begin
            rsp_bin_ff <= rdata_ff;
         end else begin
            rsp_bin_ff <= '0;
         end
         rsp_max_ff <= largest_in;
         rsp_ign_ff <= is_count && ign;
      end
   end

   assign rsp_bin_count = rsp_bin_ff;
   assign rsp_max_count = rsp_max_ff;
   assign rsp_ignored   = rsp_ign_ff;

endmodule

### src/multichannel_byte_histogram_top.sv
// A count or read transaction is captured when accepted, reads its bin in ST_READ, then in ST_UPDATE
// updates a counted bin and loads the response register; no new request is taken before it returns to idle.
// A clear transaction sweeps all 1024 bins, one per cycle, and then returns its result.
// Reset is synchronous and active high; after reset the same sweep of all 1024 bins runs before requests are taken.
// Configuration writes are taken on any cycle, including during a sweep.
`timescale 1ns / 1ps

module multichannel_byte_histogram_top (
   input  logic                              clock,
   input  logic                              reset,
   mbh_req_if.sink                           req_bus,
   mbh_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_enable,
   input  mbh_pkg::csr_index_type            csr_index,
   input  logic [mbh_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   mbh_pkg::ctrl_cmd_type    ctrl;
   mbh_pkg::ctrl_status_type status;

   mbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl),
      .status    (status)
   );

   mbh_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_cmd          (req_bus.cmd),
      .req_pixel_value  (req_bus.pixel_value),
      .req_read_channel (req_bus.read_channel),
      .req_read_bin     (req_bus.read_bin),
      .ctrl             (ctrl),
      .status           (status),
      .rsp_bin_count    (rsp_bus.bin_count),
      .rsp_max_count    (rsp_bus.max_count),
      .rsp_ignored      (rsp_bus.ignored)
   );

endmodule

### src/mbh_checker.sv
// Port-level assertions for the histogram top level and their bind.
`timescale 1ns / 1ps
`include "multichannel_byte_histogram_top_defines.svh"

module mbh_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mbh_pkg::count_type rsp_bin_count,
   input logic               rsp_ignored
);

   `MBH_ASSERT_NXT(no_rsp_after_reset, clock, reset, !rsp_valid)
   `MBH_ASSERT_NXT(busy_after_reset, clock, reset, !req_ready)
   `MBH_ASSERT_NXT(rsp_holds_when_stalled, clock, !reset && rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_bin_count) && $stable(rsp_ignored))
   `MBH_ASSERT_IMP(ignored_has_no_bin, clock, rsp_valid,
                   !(rsp_ignored && (rsp_bin_count != '0)))

endmodule

bind multichannel_byte_histogram_top mbh_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_bin_count (rsp_bus.bin_count),
   .rsp_ignored   (rsp_bus.ignored)
);
